// File: sv/cnte_pkg.sv
// shared types and constants for the child node table with timeout eviction
// no dependencies; imported by child_node_table_timeout_evict

package cnte_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_TOUCH  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_SCAN   = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_TIMEOUT  = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WALK   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

endpackage

// File: sv/child_node_table_timeout_evict.sv
// child node table: id lookup, touch with append or timeout eviction, check and scan
// one shared age subtract and compare unit walks the slots; depends on cnte_pkg
//
//   channel | handshake                   | payload
//   input   | i_in_valid / o_in_stall     | i_cmd i_node_id i_now_ms i_slot_index
//   output  | o_out_valid / i_out_stall   | o_slot o_ok o_online o_online_count o_online_bitmap
//   config  | i_cfg_we                    | i_cfg_index i_cfg_data
//
// scan walks every used slot, touch and look up walk up to a match or a free slot: one slot
// a cycle through the shared age unit, then a finish step; check reads only its given slot.
// one transaction at a time; o_in_stall is high from accept until the result is registered.
// a result waiting under i_out_stall holds the finish step, and a new transaction is
// accepted as soon as the result register is loaded.
// reset clears the online flags and the fill count at once; no clearing pass.

module child_node_table_timeout_evict
    import cnte_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_cmd,
    input  logic [15:0]         i_node_id,
    input  logic [31:0]         i_now_ms,
    input  logic [3:0]          i_slot_index,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [3:0]          o_slot,
    output logic                o_ok,
    output logic                o_online,
    output logic [4:0]          o_online_count,
    output logic [15:0]         o_online_bitmap,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    t_state r_state;
    t_cmd   r_cmd;

    logic [15:0]      r_ids  [DEPTH];
    logic [31:0]      r_seen [DEPTH];
    logic [DEPTH-1:0] r_flags;
    logic [CNT_W-1:0] r_used;
    logic [4:0]       r_capacity;
    logic [31:0]      r_timeout;

    logic [15:0]      r_id;
    logic [31:0]      r_now;
    logic [CNT_W-1:0] r_idx;
    logic             r_best_ok;
    logic [IDX_W-1:0] r_best;
    logic [31:0]      r_best_age;

    logic [IDX_W-1:0] r_res_slot;
    logic             r_res_ok;
    logic             r_res_onl;
    logic [CNT_W-1:0] r_res_cnt;
    logic [DEPTH-1:0] r_res_bmp;

    logic             r_out_valid;
    logic [3:0]       r_out_slot;
    logic             r_out_ok;
    logic             r_out_onl;
    logic [4:0]       r_out_cnt;
    logic [15:0]      r_out_bmp;

    logic [IDX_W-1:0] w_ri;
    logic             w_in_use;
    logic [31:0]      w_age;
    logic             w_exp;
    logic             w_match;
    logic             w_better;
    logic [CNT_W-1:0] w_eff_cap;
    logic             w_bad;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_idx;
    logic             w_accept;
    logic             w_load;
    logic [DEPTH-1:0] w_used_mask;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_load     = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    // shared slot unit: one slot read, one age subtract, the id match and the two age compares
    assign w_ri     = r_idx[IDX_W-1:0];
    assign w_in_use = (r_idx < r_used);
    assign w_age    = r_now - r_seen[w_ri];
    assign w_exp    = !r_flags[w_ri] || (w_age > r_timeout);
    assign w_match  = w_in_use && (r_ids[w_ri] == r_id);
    assign w_better = !r_best_ok || (w_age > r_best_age);

    assign w_eff_cap = (CNT_W'(r_capacity) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                            : CNT_W'(r_capacity);
    assign w_bad     = (r_id == 16'd0) || ((r_cmd == CMD_TOUCH) && (w_eff_cap == '0));

    always_comb begin
        w_wr_en  = 1'b0;
        w_wr_idx = w_ri;
        if (r_state == S_WALK && r_cmd == CMD_TOUCH && !w_bad) begin
            if (w_match) begin
                w_wr_en = 1'b1;
            end else if (!w_in_use) begin
                if (r_used < w_eff_cap) begin
                    w_wr_en  = 1'b1;
                    w_wr_idx = r_used[IDX_W-1:0];
                end else if (r_best_ok) begin
                    w_wr_en  = 1'b1;
                    w_wr_idx = r_best;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            w_used_mask[k] = (CNT_W'(k) < r_used);
        end
    end

    // table payload, only read below the fill count
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ids[w_wr_idx]  <= r_id;
            r_seen[w_wr_idx] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(i_cmd);
            r_id  <= i_node_id;
            r_now <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flags     <= '0;
            r_used      <= '0;
            r_capacity  <= 5'd16;
            r_timeout   <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_best_ok   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_index))
                    REG_CAPACITY: r_capacity <= i_cfg_data[4:0];
                    REG_TIMEOUT:  r_timeout  <= i_cfg_data;
                    default:      ;
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_wr_en) begin
                r_flags[w_wr_idx] <= 1'b1;
                if (!w_match && !w_in_use && r_used < w_eff_cap) begin
                    r_used <= r_used + 1'b1;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state    <= S_WALK;
                        r_idx      <= (t_cmd'(i_cmd) == CMD_CHECK) ? CNT_W'(i_slot_index) : '0;
                        r_best_ok  <= 1'b0;
                        r_res_slot <= '0;
                        r_res_ok   <= 1'b0;
                        r_res_onl  <= 1'b0;
                        r_res_cnt  <= '0;
                        r_res_bmp  <= '0;
                    end
                end
                S_WALK: begin
                    case (r_cmd) inside
                        CMD_TOUCH, CMD_LOOKUP: begin
                            if (w_bad) begin
                                r_state <= S_FINISH;
                            end else if (w_in_use && !w_match) begin
                                if (r_cmd == CMD_TOUCH && w_exp && w_better) begin
                                    r_best_ok  <= 1'b1;
                                    r_best     <= w_ri;
                                    r_best_age <= w_age;
                                end
                                r_idx <= r_idx + 1'b1;
                            end else begin
                                r_state <= S_FINISH;
                                if (w_match) begin
                                    r_res_ok   <= 1'b1;
                                    r_res_slot <= w_ri;
                                end else if (w_wr_en) begin
                                    r_res_ok   <= 1'b1;
                                    r_res_slot <= w_wr_idx;
                                end
                            end
                        end
                        CMD_CHECK: begin
                            r_state <= S_FINISH;
                            if (w_in_use) begin
                                if (w_exp) begin
                                    r_flags[w_ri] <= 1'b0;
                                end
                                r_res_onl <= !w_exp;
                            end
                        end
                        default: begin
                            if (w_in_use) begin
                                if (w_exp) begin
                                    r_flags[w_ri] <= 1'b0;
                                end else begin
                                    r_res_cnt       <= r_res_cnt + 1'b1;
                                    r_res_bmp[w_ri] <= 1'b1;
                                end
                                r_idx <= r_idx + 1'b1;
                            end else begin
                                r_state <= S_FINISH;
                            end
                        end
                    endcase
                end
                S_FINISH: begin
                    // wait for the previous result to leave before overwriting it
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_slot <= 4'(r_res_slot);
            r_out_ok   <= r_res_ok;
            r_out_onl  <= r_res_onl;
            r_out_cnt  <= 5'(r_res_cnt);
            r_out_bmp  <= 16'(r_res_bmp);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_slot          = r_out_slot;
    assign o_ok            = r_out_ok;
    assign o_online        = r_out_onl;
    assign o_online_count  = r_out_cnt;
    assign o_online_bitmap = r_out_bmp;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(DEPTH))
        else $error("fill count beyond table depth");

    a_flags_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flags & ~w_used_mask) == '0)
        else $error("online flag set on a slot not in use");

    a_count_bitmap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_online_count) == $countones(o_online_bitmap)))
        else $error("online count disagrees with bitmap");

    a_ok_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_online || o_online_bitmap != '0)) |-> !o_ok)
        else $error("ok raised on check or scan result");

    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_WALK))
        else $error("accepted transaction did not start the slot walk");

endmodule
